[design/mcfd_pkg.sv]
// Shared types, constants and helper functions for the motor CAN frame decoder.
// No dependencies; every other design file but mcfd_if imports this package.
package mcfd_pkg;

  // Default depth of the queue between front and back end.
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Known extended frame identifiers.
  localparam logic [28:0] ID_PEDAL  = 29'h02F83200;
  localparam logic [28:0] ID_RIDE   = 29'h02F83201;
  localparam logic [28:0] ID_WHEEL  = 29'h02F83203;
  localparam logic [28:0] ID_ALIVE  = 29'h02F83204;
  localparam logic [28:0] ID_ASSIST = 29'h02F83206;
  localparam logic [28:0] ID_ODO    = 29'h02F8320E;

  // Identifier and fixed bytes of the keepalive frame.
  localparam logic [31:0] ID_KEEPALIVE   = 32'h03106300;
  localparam logic [7:0]  KA_BYTE_ZERO   = 8'h05;
  localparam logic [7:0]  KA_BYTE_TWO    = 8'h00;
  localparam logic [7:0]  KA_BYTE_THREE  = 8'h01;

  // Temperature bytes carry this bias.
  localparam logic [7:0] TEMP_BIAS = 8'd40;

  // Frame lengths that the alive and odometer frames require.
  localparam logic [3:0] LEN_ALIVE = 4'd1;
  localparam logic [3:0] LEN_ODO   = 4'd8;

  // Alive byte values.
  localparam logic [7:0] ALIVE_GOODBYE = 8'h00;
  localparam logic [7:0] ALIVE_HELLO   = 8'h01;

  // Assist levels and their byte codes on the bus.
  localparam logic signed [7:0] LEVEL_NONE = -8'sd128;
  localparam logic signed [7:0] LEVEL_WALK = -8'sd1;
  localparam logic signed [7:0] LEVEL_OFF  = 8'sd0;
  localparam logic signed [7:0] LEVEL_1    = 8'sd1;
  localparam logic signed [7:0] LEVEL_2    = 8'sd2;
  localparam logic signed [7:0] LEVEL_3    = 8'sd3;
  localparam logic signed [7:0] LEVEL_4    = 8'sd4;
  localparam logic signed [7:0] LEVEL_5    = 8'sd5;

  localparam logic [7:0] CODE_WALK = 8'h06;
  localparam logic [7:0] CODE_OFF  = 8'h00;
  localparam logic [7:0] CODE_1    = 8'h0b;
  localparam logic [7:0] CODE_2    = 8'h0d;
  localparam logic [7:0] CODE_3    = 8'h15;
  localparam logic [7:0] CODE_4    = 8'h17;
  localparam logic [7:0] CODE_5    = 8'h03;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_TORQUE_TRIM      = 2'd0,
    REG_KEEPALIVE_PERIOD = 2'd1,
    REG_DROPOUT_WINDOW   = 2'd2,
    REG_VOLTAGE_JITTER   = 2'd3
  } reg_index_t;

  // Configuration reset values.
  localparam logic [15:0] TORQUE_TRIM_RST      = 16'd0;
  localparam logic [15:0] KEEPALIVE_PERIOD_RST = 16'd100;
  localparam logic [15:0] DROPOUT_WINDOW_RST   = 16'd3000;
  localparam logic [15:0] VOLTAGE_JITTER_RST   = 16'd10;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_PEDAL     = 3'd0,
    KIND_RIDE      = 3'd1,
    KIND_WHEEL     = 3'd2,
    KIND_ALIVE     = 3'd3,
    KIND_ASSIST    = 3'd4,
    KIND_ODO       = 3'd5,
    KIND_KEEPALIVE = 3'd6
  } kind_t;

  // One classified request as it travels from front to back end. The result
  // fields are already laid out as the update result would carry them.
  typedef struct packed {
    logic              upd;         // a known, well-formed frame
    kind_t             kind;
    logic [31:0]       word_one;
    logic [31:0]       word_two;
    logic [15:0]       half_one;
    logic [15:0]       half_two;
    logic signed [7:0] small_one;
    logic signed [7:0] small_two;
    logic [15:0]       torque;      // offset and saturated torque
    logic [31:0]       now_ms;
    logic [7:0]        level_code;  // encoded requested level
  } job_t;

  // One result as held in the output register.
  typedef struct packed {
    kind_t             kind;
    logic              last;
    logic [31:0]       word_one;
    logic [31:0]       word_two;
    logic [15:0]       half_one;
    logic [15:0]       half_two;
    logic signed [7:0] small_one;
    logic signed [7:0] small_two;
  } result_t;

  // Floor of x / 5 by reciprocal multiplication, exact for all 16-bit x.
  function automatic logic [15:0] div5(input logic [15:0] x);
    logic [31:0] prod;
    prod = {16'b0, x} * 32'd52429;
    return {2'b00, prod[31:18]};
  endfunction

  // Bus code of a requested assist level; unknown levels send the off code.
  function automatic logic [7:0] level_code(input logic signed [7:0] lv);
    logic [7:0] code;
    case (lv)
      LEVEL_WALK: code = CODE_WALK;
      LEVEL_1:    code = CODE_1;
      LEVEL_2:    code = CODE_2;
      LEVEL_3:    code = CODE_3;
      LEVEL_4:    code = CODE_4;
      LEVEL_5:    code = CODE_5;
      default:    code = CODE_OFF;
    endcase
    return code;
  endfunction

  // Keepalive result carrying the given level code.
  function automatic result_t keepalive_result(input logic [7:0] code);
    result_t r;
    r           = '0;
    r.kind      = KIND_KEEPALIVE;
    r.last      = 1'b1;
    r.word_one  = ID_KEEPALIVE;
    r.word_two  = {KA_BYTE_THREE, KA_BYTE_TWO, code, KA_BYTE_ZERO};
    return r;
  endfunction

endpackage

[design/mcfd_if.sv]
// Channel interfaces of the motor CAN frame decoder: received frames in,
// decoded results out. Depends on nothing.
interface mcfd_frame_if;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [28:0]       frame_ident;
  logic [3:0]        frame_length;
  logic [63:0]       payload;
  logic [31:0]       now_ms;
  logic signed [7:0] requested_level;

  modport source (
    output valid, cmd, frame_ident, frame_length, payload, now_ms, requested_level,
    input  ready
  );
  modport sink (
    input  valid, cmd, frame_ident, frame_length, payload, now_ms, requested_level,
    output ready
  );
endinterface

interface mcfd_update_if;
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic              last;
  logic [31:0]       word_one;
  logic [31:0]       word_two;
  logic [15:0]       half_one;
  logic [15:0]       half_two;
  logic signed [7:0] small_one;
  logic signed [7:0] small_two;

  modport source (
    output valid, kind, last, word_one, word_two, half_one, half_two, small_one, small_two,
    input  ready
  );
  modport sink (
    input  valid, kind, last, word_one, word_two, half_one, half_two, small_one, small_two,
    output ready
  );
endinterface

[design/mcfd_queue.sv]
// Short first-in first-out queue of classified requests between the front
// and back end. Depends on mcfd_pkg for job_t.
module mcfd_queue
  import mcfd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

[design/mcfd_front.sv]
// Front end: accepts frame requests and classifies them into jobs for the
// queue. Depends on mcfd_pkg and the mcfd_frame_if interface.
module mcfd_front
  import mcfd_pkg::*;
(
  mcfd_frame_if.sink  frame,
  input  logic [15:0] torque_trim,
  input  logic        queue_full,
  output logic        push,
  output job_t        push_job
);

  logic [7:0]         b0;
  logic [7:0]         b2;
  logic [7:0]         cadence;
  logic [15:0]        raw_torque;
  logic signed [17:0] torque_sum;
  logic [15:0]        torque_sat;
  logic [15:0]        wheel_base;
  logic [15:0]        wheel_size;

  // A request is taken whenever the queue has room.
  assign frame.ready = !queue_full;
  assign push        = frame.valid && !queue_full;

  // Payload bytes and derived pedal and wheel values.
  always_comb begin
    b0         = frame.payload[7:0];
    b2         = frame.payload[23:16];
    cadence    = frame.payload[31:24];
    raw_torque = frame.payload[47:32];
    torque_sum = $signed({2'b00, raw_torque}) +
                 $signed({{2{torque_trim[15]}}, torque_trim});
    torque_sat = torque_sum[16] ? 16'hFFFF : torque_sum[15:0];
    wheel_base = {4'b0, frame.payload[31:24], b2[7:4]};
    wheel_size = (wheel_base << 3) + (wheel_base << 1) + {12'b0, b2[3:0]};
  end

  // Classify the frame and lay out its update fields.
  always_comb begin
    push_job            = '0;
    push_job.kind       = KIND_KEEPALIVE;
    push_job.now_ms     = frame.now_ms;
    push_job.level_code = level_code(frame.requested_level);
    if (!frame.cmd) begin
      case (frame.frame_ident)
        ID_PEDAL: begin
          // A negative offset torque drops the frame.
          push_job.upd      = !torque_sum[17];
          push_job.kind     = KIND_PEDAL;
          push_job.half_one = {8'b0, cadence};
          push_job.half_two = raw_torque;
          push_job.torque   = torque_sat;
        end
        ID_RIDE: begin
          push_job.upd       = 1'b1;
          push_job.kind      = KIND_RIDE;
          push_job.half_one  = frame.payload[15:0];
          push_job.half_two  = frame.payload[31:16];
          push_job.word_one  = {16'b0, frame.payload[47:32]};
          push_job.small_one = $signed(frame.payload[55:48] - TEMP_BIAS);
          push_job.small_two = $signed(frame.payload[63:56] - TEMP_BIAS);
        end
        ID_WHEEL: begin
          push_job.upd      = 1'b1;
          push_job.kind     = KIND_WHEEL;
          push_job.half_one = frame.payload[15:0];
          push_job.half_two = wheel_size;
          push_job.word_one = {16'b0, frame.payload[47:32]};
        end
        ID_ALIVE: begin
          push_job.upd      = (frame.frame_length == LEN_ALIVE) &&
                              (b0 == ALIVE_GOODBYE || b0 == ALIVE_HELLO);
          push_job.kind     = KIND_ALIVE;
          push_job.word_one = {31'b0, b0[0]};
        end
        ID_ASSIST: begin
          push_job.upd  = 1'b1;
          push_job.kind = KIND_ASSIST;
          case (b0)
            CODE_WALK: push_job.small_one = LEVEL_WALK;
            CODE_OFF:  push_job.small_one = LEVEL_OFF;
            CODE_1:    push_job.small_one = LEVEL_1;
            CODE_2:    push_job.small_one = LEVEL_2;
            CODE_3:    push_job.small_one = LEVEL_3;
            CODE_4:    push_job.small_one = LEVEL_4;
            CODE_5:    push_job.small_one = LEVEL_5;
            default:   push_job.upd       = 1'b0;
          endcase
        end
        ID_ODO: begin
          push_job.upd      = (frame.frame_length == LEN_ODO);
          push_job.kind     = KIND_ODO;
          push_job.word_one = frame.payload[31:0];
          push_job.word_two = frame.payload[63:32];
        end
        default: begin
          push_job.upd = 1'b0;
        end
      endcase
    end
  end

endmodule

[design/mcfd_back.sv]
// Back end: compares each job with the last reported values, runs the
// keepalive timer and drives the result register. Depends on mcfd_pkg and
// the mcfd_update_if interface.
module mcfd_back
  import mcfd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  job_t          head,
  output logic          pop,
  input  logic [15:0]   keepalive_period,
  input  logic [15:0]   dropout_window,
  input  logic [15:0]   voltage_jitter,
  mcfd_update_if.source update
);

  // Last reported values.
  logic [7:0]        prev_cadence;
  logic [15:0]       prev_torque;
  logic [31:0]       valid_torque_time;
  logic [15:0]       ride_speed;
  logic [15:0]       ride_current;
  logic [15:0]       ride_voltage;
  logic [7:0]        ride_motor_temp;
  logic [7:0]        ride_ctrl_temp;
  logic [15:0]       prev_assist_speed;
  logic [15:0]       prev_wheel_size;
  logic [15:0]       prev_circumference;
  logic              alive_flag;
  logic signed [7:0] prev_level;
  logic [31:0]       keepalive_time;

  // Output register and the keepalive waiting behind an update.
  logic              out_valid;
  logic              out_valid_next;
  result_t           out_res;
  result_t           out_res_next;
  logic              pend_valid;
  logic              pend_valid_next;
  logic [7:0]        pend_code;

  logic              can_load;
  logic              ka_hit;
  logic              upd_hit;
  logic [31:0]       ka_elapsed;
  logic [31:0]       torque_age;
  logic [15:0]       cadence_limit;
  logic [15:0]       torque_limit;
  logic              dropout;
  logic [15:0]       volt_delta;
  result_t           upd_res;
  result_t           ka_res;

  assign can_load = !out_valid || update.ready;
  assign pop      = can_load && !pend_valid && head_valid;

  // Keepalive timer check.
  assign ka_elapsed = head.now_ms - keepalive_time;
  assign ka_hit     = ka_elapsed > {16'b0, keepalive_period};

  // Torque dropout check against the last valid pedal report.
  always_comb begin
    torque_age    = head.now_ms - valid_torque_time;
    cadence_limit = div5({6'b0, prev_cadence, 2'b00});
    torque_limit  = div5(prev_torque);
    dropout       = (head.half_one[7:0] != 8'd0) &&
                    ({8'b0, head.half_one[7:0]} > cadence_limit) &&
                    (head.torque < torque_limit) &&
                    (torque_age < {16'b0, dropout_window});
  end

  // Decide whether the job reports a change.
  always_comb begin
    volt_delta = (head.word_one[15:0] > ride_voltage) ?
                 head.word_one[15:0] - ride_voltage :
                 ride_voltage - head.word_one[15:0];
    case (head.kind)
      KIND_PEDAL: begin
        upd_hit = !(head.half_one[7:0] == prev_cadence && head.torque == prev_torque) &&
                  !dropout;
      end
      KIND_RIDE: begin
        upd_hit = !(head.half_one == ride_speed && head.half_two == ride_current &&
                    volt_delta <= voltage_jitter &&
                    head.small_one == $signed(ride_motor_temp) &&
                    head.small_two == $signed(ride_ctrl_temp));
      end
      KIND_WHEEL: begin
        upd_hit = !(head.half_one == prev_assist_speed && head.half_two == prev_wheel_size &&
                    head.word_one[15:0] == prev_circumference);
      end
      KIND_ALIVE:  upd_hit = head.word_one[0] != alive_flag;
      KIND_ASSIST: upd_hit = head.small_one != prev_level;
      KIND_ODO:    upd_hit = 1'b1;
      default:     upd_hit = 1'b0;
    endcase
    upd_hit = upd_hit && head.upd;
  end

  // Candidate results.
  always_comb begin
    upd_res           = '0;
    upd_res.kind      = head.kind;
    upd_res.last      = !ka_hit;
    upd_res.word_one  = head.word_one;
    upd_res.word_two  = head.word_two;
    upd_res.half_one  = head.half_one;
    upd_res.half_two  = head.half_two;
    upd_res.small_one = head.small_one;
    upd_res.small_two = head.small_two;
    ka_res            = keepalive_result(pend_valid ? pend_code : head.level_code);
  end

  // Next output: a waiting keepalive first, then the head job's results.
  always_comb begin
    out_valid_next  = out_valid;
    out_res_next    = out_res;
    pend_valid_next = pend_valid;
    if (can_load) begin
      out_valid_next = 1'b0;
      if (pend_valid) begin
        out_valid_next  = 1'b1;
        out_res_next    = ka_res;
        pend_valid_next = 1'b0;
      end else if (head_valid && upd_hit) begin
        out_valid_next  = 1'b1;
        out_res_next    = upd_res;
        pend_valid_next = ka_hit;
      end else if (head_valid && ka_hit) begin
        out_valid_next = 1'b1;
        out_res_next   = ka_res;
      end
    end
  end

  // Control state of the output side.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      pend_valid <= pend_valid_next;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    out_res <= out_res_next;
    if (pop) begin
      pend_code <= head.level_code;
    end
  end

  // Reported values advance when a job reports, the keepalive time on a keepalive.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_cadence       <= '0;
      prev_torque        <= '0;
      valid_torque_time  <= '0;
      ride_speed         <= '0;
      ride_current       <= '0;
      ride_voltage       <= '0;
      ride_motor_temp    <= '0;
      ride_ctrl_temp     <= '0;
      prev_assist_speed  <= '0;
      prev_wheel_size    <= '0;
      prev_circumference <= '0;
      alive_flag         <= 1'b0;
      prev_level         <= LEVEL_NONE;
      keepalive_time     <= '0;
    end else if (pop) begin
      if (upd_hit) begin
        case (head.kind)
          KIND_PEDAL: begin
            valid_torque_time <= head.now_ms;
            prev_cadence      <= head.half_one[7:0];
            prev_torque       <= head.torque;
          end
          KIND_RIDE: begin
            ride_speed      <= head.half_one;
            ride_current    <= head.half_two;
            ride_voltage    <= head.word_one[15:0];
            ride_motor_temp <= head.small_one;
            ride_ctrl_temp  <= head.small_two;
          end
          KIND_WHEEL: begin
            prev_assist_speed  <= head.half_one;
            prev_wheel_size    <= head.half_two;
            prev_circumference <= head.word_one[15:0];
          end
          KIND_ALIVE:  alive_flag <= head.word_one[0];
          KIND_ASSIST: prev_level <= head.small_one;
          default: begin
          end
        endcase
      end
      if (ka_hit) begin
        keepalive_time <= head.now_ms;
      end
    end
  end

  // Drive the result channel.
  assign update.valid     = out_valid;
  assign update.kind      = out_res.kind;
  assign update.last      = out_res.last;
  assign update.word_one  = out_res.word_one;
  assign update.word_two  = out_res.word_two;
  assign update.half_one  = out_res.half_one;
  assign update.half_two  = out_res.half_two;
  assign update.small_one = out_res.small_one;
  assign update.small_two = out_res.small_two;

endmodule

[design/motor_can_frame_decoder.sv]
// Motor CAN frame decoder: decodes received motor frames and time ticks into
// pedal, ride, wheel, alive, assist and odometer updates, suppressing
// unchanged values, and adds a keepalive result whenever the keepalive
// period has run out. The front end classifies a request in the cycle it is
// accepted and takes a new request every cycle while its queue of
// QUEUE_DEPTH entries has room. The back end pops one request per cycle into
// a single output register unless the result channel stalls; a request with
// an update plus a keepalive holds back the next pop until its keepalive is
// loaded. A request passes through its queue entry and then the output register
// before its first result appears. Configuration registers are to be written
// by the user only while the block is idle; the block does not enforce this.
// Depends on mcfd_pkg, mcfd_if, mcfd_front, mcfd_queue and mcfd_back.
module motor_can_frame_decoder
  import mcfd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  mcfd_frame_if.sink    frame,
  mcfd_update_if.source update,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  logic [15:0] torque_trim;
  logic [15:0] keepalive_period;
  logic [15:0] dropout_window;
  logic [15:0] voltage_jitter;

  logic        queue_full;
  logic        push;
  job_t        push_job;
  logic        pop;
  logic        head_valid;
  job_t        head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      torque_trim      <= TORQUE_TRIM_RST;
      keepalive_period <= KEEPALIVE_PERIOD_RST;
      dropout_window   <= DROPOUT_WINDOW_RST;
      voltage_jitter   <= VOLTAGE_JITTER_RST;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_TORQUE_TRIM:      torque_trim      <= cfg_data;
        REG_KEEPALIVE_PERIOD: keepalive_period <= cfg_data;
        REG_DROPOUT_WINDOW:   dropout_window   <= cfg_data;
        REG_VOLTAGE_JITTER:   voltage_jitter   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Request classification.
  mcfd_front u_front (
    .frame       (frame),
    .torque_trim (torque_trim),
    .queue_full  (queue_full),
    .push        (push),
    .push_job    (push_job)
  );

  // Queue between front and back end.
  mcfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Change detection, keepalive and result register.
  mcfd_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .keepalive_period (keepalive_period),
    .dropout_window   (dropout_window),
    .voltage_jitter   (voltage_jitter),
    .update           (update)
  );

endmodule

[design/mcfd_checker.sv]
// Port-level checks on the result channel of the motor CAN frame decoder,
// bound to the top level. Depends on mcfd_pkg and motor_can_frame_decoder.
module mcfd_checker
  import mcfd_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              valid,
  input logic              ready,
  input logic [2:0]        kind,
  input logic              last,
  input logic [31:0]       word_one,
  input logic [31:0]       word_two,
  input logic [15:0]       half_one,
  input logic signed [7:0] small_one,
  input logic signed [7:0] small_two
);

  // A stalled result holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(kind) && $stable(last) &&
                        $stable(word_one) && $stable(word_two))
    else $error("result changed while stalled");

  // An update that is not last is followed at once by its keepalive.
  a_pair: assert property (@(posedge clk) disable iff (rst)
    valid && ready && !last |=> valid && kind == KIND_KEEPALIVE && last)
    else $error("second result of a request missing");

  // A keepalive always closes its request and carries the fixed frame parts.
  a_keepalive: assert property (@(posedge clk) disable iff (rst)
    valid && kind == KIND_KEEPALIVE |-> last && word_one == ID_KEEPALIVE &&
      word_two[7:0] == KA_BYTE_ZERO && word_two[31:24] == KA_BYTE_THREE)
    else $error("malformed keepalive result");

  // A pedal update leaves the fields of other kinds at zero.
  a_pedal: assert property (@(posedge clk) disable iff (rst)
    valid && kind == KIND_PEDAL |-> word_one == '0 && word_two == '0 &&
      half_one[15:8] == '0 && small_one == '0 && small_two == '0)
    else $error("pedal result carries stray fields");

endmodule

bind motor_can_frame_decoder mcfd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .valid     (update.valid),
  .ready     (update.ready),
  .kind      (update.kind),
  .last      (update.last),
  .word_one  (update.word_one),
  .word_two  (update.word_two),
  .half_one  (update.half_one),
  .small_one (update.small_one),
  .small_two (update.small_two)
);

[tb/sv/mcfd_sb_pkg.sv]
// Request type and update scoreboard for the motor CAN frame decoder bench.
// Depends on mcfd_pkg for identifiers, codes, register indexes and result_t.
package mcfd_sb_pkg;
  import mcfd_pkg::*;

  // One request as offered on the frame channel.
  typedef struct {
    logic              cmd;
    logic [28:0]       ident;
    logic [3:0]        len;
    logic [63:0]       payload;
    logic [31:0]       now_ms;
    logic signed [7:0] level;
  } frame_req_t;

  class frame_decoder_sb;
    // Configuration as last written.
    logic signed [15:0] torque_trim;
    logic [15:0]        keepalive_period;
    logic [15:0]        dropout_window;
    logic [15:0]        voltage_jitter;

    // Last reported values of each update kind.
    logic [7:0]         prev_cadence;
    logic [15:0]        prev_torque;
    logic [31:0]        torque_time;
    logic [15:0]        ride_speed;
    logic [15:0]        ride_current;
    logic [15:0]        ride_voltage;
    logic [7:0]         ride_motor_temp;
    logic [7:0]         ride_ctrl_temp;
    logic [15:0]        prev_assist_speed;
    logic [15:0]        prev_wheel_size;
    logic [15:0]        prev_circumference;
    logic               alive_flag;
    logic signed [7:0]  prev_level;
    logic [31:0]        keepalive_time;

    // Updates and keepalives still owed by the block, oldest first.
    result_t            due_updates[$];
    int unsigned        errors;

    function new();
      torque_trim        = TORQUE_TRIM_RST;
      keepalive_period   = KEEPALIVE_PERIOD_RST;
      dropout_window     = DROPOUT_WINDOW_RST;
      voltage_jitter     = VOLTAGE_JITTER_RST;
      prev_cadence       = '0;
      prev_torque        = '0;
      torque_time        = '0;
      ride_speed         = '0;
      ride_current       = '0;
      ride_voltage       = '0;
      ride_motor_temp    = '0;
      ride_ctrl_temp     = '0;
      prev_assist_speed  = '0;
      prev_wheel_size    = '0;
      prev_circumference = '0;
      alive_flag         = 1'b0;
      prev_level         = LEVEL_NONE;
      keepalive_time     = '0;
      errors             = 0;
    endfunction

    function void write_reg(input reg_index_t idx, input logic [15:0] val);
      case (idx)
        REG_TORQUE_TRIM:      torque_trim      = val;
        REG_KEEPALIVE_PERIOD: keepalive_period = val;
        REG_DROPOUT_WINDOW:   dropout_window   = val;
        REG_VOLTAGE_JITTER:   voltage_jitter   = val;
        default: ;
      endcase
    endfunction

    // Bus code sent in the keepalive for a requested level.
    function logic [7:0] bus_code(input logic signed [7:0] lv);
      case (lv)
        LEVEL_WALK: return CODE_WALK;
        LEVEL_1:    return CODE_1;
        LEVEL_2:    return CODE_2;
        LEVEL_3:    return CODE_3;
        LEVEL_4:    return CODE_4;
        LEVEL_5:    return CODE_5;
        default:    return CODE_OFF;
      endcase
    endfunction

    // Decodes one received frame and updates the stored values. Returns 1 when
    // the frame yields an update, which is then left in upd.
    function bit decode_frame(input frame_req_t r, output result_t upd);
      logic [7:0]        cad, b2, b3, mt, ct;
      logic [15:0]       raw, tq, spd, cur, vol, mas, ws, circ;
      logic [31:0]       since;
      logic signed [7:0] lv;
      int                sum, vdiff, ws_full;
      bit                known;
      upd   = '0;
      lv    = LEVEL_OFF;
      known = 1'b1;
      case (r.ident)
        ID_PEDAL: begin
          cad = r.payload[31:24];
          raw = r.payload[47:32];
          sum = int'(raw) + int'(torque_trim);
          // A torque pushed below zero by the offset is dropped.
          if (sum < 0) return 1'b0;
          tq = (sum > 65535) ? 16'hFFFF : sum[15:0];
          if (cad == prev_cadence && tq == prev_torque) return 1'b0;
          // A sudden torque collapse at steady cadence is a dropout.
          since = r.now_ms - torque_time;
          if (cad != 8'd0 && int'(cad) > (4 * int'(prev_cadence)) / 5 &&
              int'(tq) < int'(prev_torque) / 5 && since < {16'b0, dropout_window})
            return 1'b0;
          torque_time  = r.now_ms;
          prev_cadence = cad;
          prev_torque  = tq;
          upd.kind     = KIND_PEDAL;
          upd.half_one = {8'b0, cad};
          upd.half_two = raw;
          return 1'b1;
        end
        ID_RIDE: begin
          spd   = r.payload[15:0];
          cur   = r.payload[31:16];
          vol   = r.payload[47:32];
          mt    = r.payload[55:48] - TEMP_BIAS;
          ct    = r.payload[63:56] - TEMP_BIAS;
          vdiff = int'(vol) - int'(ride_voltage);
          if (vdiff < 0) vdiff = -vdiff;
          // Small voltage jitter alone does not count as a change.
          if (spd == ride_speed && cur == ride_current && vdiff <= int'(voltage_jitter) &&
              mt == ride_motor_temp && ct == ride_ctrl_temp)
            return 1'b0;
          ride_speed      = spd;
          ride_current    = cur;
          ride_voltage    = vol;
          ride_motor_temp = mt;
          ride_ctrl_temp  = ct;
          upd.kind      = KIND_RIDE;
          upd.word_one  = {16'b0, vol};
          upd.half_one  = spd;
          upd.half_two  = cur;
          upd.small_one = mt;
          upd.small_two = ct;
          return 1'b1;
        end
        ID_WHEEL: begin
          mas     = r.payload[15:0];
          b2      = r.payload[23:16];
          b3      = r.payload[31:24];
          circ    = r.payload[47:32];
          // Wheel size: whole inches in the upper twelve bits, tenths below.
          ws_full = ((int'(b3) << 4) | (int'(b2) >> 4)) * 10 + (int'(b2) & 15);
          ws      = ws_full[15:0];
          if (mas == prev_assist_speed && ws == prev_wheel_size && circ == prev_circumference)
            return 1'b0;
          prev_assist_speed  = mas;
          prev_wheel_size    = ws;
          prev_circumference = circ;
          upd.kind     = KIND_WHEEL;
          upd.word_one = {16'b0, circ};
          upd.half_one = mas;
          upd.half_two = ws;
          return 1'b1;
        end
        ID_ALIVE: begin
          if (r.len != LEN_ALIVE) return 1'b0;
          if (r.payload[7:0] == ALIVE_GOODBYE && alive_flag) begin
            alive_flag = 1'b0;
            upd.kind   = KIND_ALIVE;
            return 1'b1;
          end
          if (r.payload[7:0] == ALIVE_HELLO && !alive_flag) begin
            alive_flag   = 1'b1;
            upd.kind     = KIND_ALIVE;
            upd.word_one = 32'd1;
            return 1'b1;
          end
          return 1'b0;
        end
        ID_ASSIST: begin
          case (r.payload[7:0])
            CODE_WALK: lv = LEVEL_WALK;
            CODE_OFF:  lv = LEVEL_OFF;
            CODE_1:    lv = LEVEL_1;
            CODE_2:    lv = LEVEL_2;
            CODE_3:    lv = LEVEL_3;
            CODE_4:    lv = LEVEL_4;
            CODE_5:    lv = LEVEL_5;
            default:   known = 1'b0;
          endcase
          if (!known || lv == prev_level) return 1'b0;
          prev_level    = lv;
          upd.kind      = KIND_ASSIST;
          upd.small_one = lv;
          return 1'b1;
        end
        ID_ODO: begin
          // The odometer is reported on every full frame, changed or not.
          if (r.len != LEN_ODO) return 1'b0;
          upd.kind     = KIND_ODO;
          upd.word_one = r.payload[31:0];
          upd.word_two = r.payload[63:32];
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    // Works out the results of one accepted request and queues them.
    function void predict_updates(input frame_req_t r);
      result_t     upd, ka;
      logic [31:0] elapsed;
      bit          has_upd;
      has_upd = 1'b0;
      if (!r.cmd) has_upd = decode_frame(r, upd);
      elapsed = r.now_ms - keepalive_time;
      if (elapsed > {16'b0, keepalive_period}) begin
        ka          = '0;
        ka.kind     = KIND_KEEPALIVE;
        ka.last     = 1'b1;
        ka.word_one = ID_KEEPALIVE;
        ka.word_two = {KA_BYTE_THREE, KA_BYTE_TWO, bus_code(r.level), KA_BYTE_ZERO};
        keepalive_time = r.now_ms;
        if (has_upd) due_updates.push_back(upd);
        due_updates.push_back(ka);
      end else if (has_upd) begin
        upd.last = 1'b1;
        due_updates.push_back(upd);
      end
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Checks one accepted result against the oldest owed one.
    function void check_update(input result_t got);
      result_t want;
      if (due_updates.size() == 0) begin
        $error("kind: expected no result, got 0x%0h", got.kind);
        errors++;
        return;
      end
      want = due_updates.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("last", want.last, got.last);
      compare_field("word_one", want.word_one, got.word_one);
      compare_field("word_two", want.word_two, got.word_two);
      compare_field("half_one", want.half_one, got.half_one);
      compare_field("half_two", want.half_two, got.half_two);
      compare_field("small_one", $unsigned(want.small_one), $unsigned(got.small_one));
      compare_field("small_two", $unsigned(want.small_two), $unsigned(got.small_two));
    endfunction
  endclass

endpackage

[tb/sv/tb_top.sv]
// Top of the motor CAN frame decoder bench: clock, reset, request driver,
// result sink and configuration phases. Depends on mcfd_pkg, mcfd_if,
// mcfd_sb_pkg and the motor_can_frame_decoder RTL.
module tb_top;
  import mcfd_pkg::*;
  import mcfd_sb_pkg::*;

  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 275;
  localparam longint      RUN_LIMIT       = 64'd9_000_000;

  // Bus codes of the assist frame, used to pick well-formed assist requests.
  localparam logic [7:0] ASSIST_CODES [7] =
    '{CODE_WALK, CODE_OFF, CODE_1, CODE_2, CODE_3, CODE_4, CODE_5};

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  mcfd_frame_if  frame();
  mcfd_update_if update();

  frame_decoder_sb sb = new();

  // Running bus time and the idle modes of both sides.
  logic [31:0] bus_ms;
  logic [63:0] last_wheel;
  bit          sender_quiet;
  bit          sink_quiet;

  always #5 clk = ~clk;

  motor_can_frame_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame),
    .update    (update),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic frame_req_t frame_of(input logic [28:0] ident, input logic [3:0] len,
                                          input logic [63:0] payload,
                                          input logic [31:0] now_ms,
                                          input logic signed [7:0] level);
    frame_req_t r;
    r.cmd     = 1'b0;
    r.ident   = ident;
    r.len     = len;
    r.payload = payload;
    r.now_ms  = now_ms;
    r.level   = level;
    return r;
  endfunction

  function automatic frame_req_t tick_of(input logic [31:0] now_ms,
                                         input logic signed [7:0] level);
    frame_req_t r;
    r     = frame_of('0, '0, '0, now_ms, level);
    r.cmd = 1'b1;
    return r;
  endfunction

  function automatic logic [63:0] ride_bytes(input logic [15:0] spd, input logic [15:0] cur,
                                             input logic [15:0] vol, input logic [7:0] mtb,
                                             input logic [7:0] ctb);
    return {ctb, mtb, vol, cur, spd};
  endfunction

  // Builds one random request. Most are well-formed frames whose content sits
  // close to the stored values, so that suppression and dropouts are reached.
  function automatic frame_req_t random_request();
    frame_req_t        r;
    int unsigned       roll;
    logic [7:0]        cad;
    logic [15:0]       raw, vol, delta;
    logic signed [7:0] lv;

    // Time mostly creeps forward, sometimes jumps, now and then anywhere.
    roll = $urandom_range(0, 99);
    if (roll < 70) bus_ms = bus_ms + $urandom_range(0, 40);
    else if (roll < 90) bus_ms = bus_ms + $urandom_range(41, 200);
    else if (roll < 98) bus_ms = bus_ms + $urandom_range(201, 5000);
    else bus_ms = $urandom;

    if ($urandom_range(0, 99) < 85) begin
      lv = 8'($urandom_range(0, 6));
      lv = lv - 8'sd1;
    end else begin
      lv = 8'($urandom);
    end

    r = frame_of('0, 4'($urandom_range(0, 8)), {$urandom, $urandom}, bus_ms, lv);
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      // Time tick, sometimes carrying a known identifier that must be ignored.
      r.cmd   = 1'b1;
      r.ident = $urandom_range(0, 1) ? 29'($urandom) : {ID_PEDAL[28:4], 4'($urandom)};
    end else if (roll < 14) begin
      r.ident = $urandom_range(0, 1) ? 29'($urandom) : {ID_PEDAL[28:4], 4'($urandom)};
    end else if (roll < 34) begin
      r.ident = ID_PEDAL;
      case ($urandom_range(0, 3))
        0: begin
          cad = sb.prev_cadence;
          raw = sb.prev_torque - sb.torque_trim;
        end
        1: begin
          cad = sb.prev_cadence + 8'($urandom_range(0, 3));
          raw = 16'($urandom_range(0, sb.prev_torque / 5)) - sb.torque_trim;
        end
        default: begin
          cad = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 130));
          raw = ($urandom_range(0, 4) < 3) ? 16'($urandom_range(0, 2000)) : 16'($urandom);
        end
      endcase
      r.payload[31:24] = cad;
      r.payload[47:32] = raw;
    end else if (roll < 52) begin
      r.ident = ID_RIDE;
      if ($urandom_range(0, 2) != 0) begin
        delta = 16'($urandom_range(0, 12));
        vol   = $urandom_range(0, 1) ? sb.ride_voltage + delta : sb.ride_voltage - delta;
        r.payload = ride_bytes(sb.ride_speed, sb.ride_current, vol,
                               sb.ride_motor_temp + TEMP_BIAS, sb.ride_ctrl_temp + TEMP_BIAS);
        if ($urandom_range(0, 4) == 0) r.payload[55:48] = r.payload[55:48] + 8'd1;
        if ($urandom_range(0, 4) == 0) r.payload[15:0] = r.payload[15:0] + 16'd1;
      end
    end else if (roll < 64) begin
      r.ident = ID_WHEEL;
      if ($urandom_range(0, 2) == 0) r.payload[47:0] = last_wheel[47:0];
      last_wheel = r.payload;
    end else if (roll < 76) begin
      r.ident = ID_ALIVE;
      if ($urandom_range(0, 4) != 0) r.len = LEN_ALIVE;
      if ($urandom_range(0, 6) != 0)
        r.payload[7:0] = $urandom_range(0, 1) ? ALIVE_HELLO : ALIVE_GOODBYE;
    end else if (roll < 88) begin
      r.ident = ID_ASSIST;
      if ($urandom_range(0, 4) != 0) r.payload[7:0] = ASSIST_CODES[$urandom_range(0, 6)];
    end else begin
      r.ident = ID_ODO;
      if ($urandom_range(0, 6) != 0) r.len = LEN_ODO;
    end
    return r;
  endfunction

  // Offers one request and holds it until the block takes it.
  task automatic push_request(input frame_req_t r);
    int unsigned gap;
    frame.valid           <= 1'b1;
    frame.cmd             <= r.cmd;
    frame.frame_ident     <= r.ident;
    frame.frame_length    <= r.len;
    frame.payload         <= r.payload;
    frame.now_ms          <= r.now_ms;
    frame.requested_level <= r.level;
    @(posedge clk);
    while (!frame.ready) @(posedge clk);
    sb.predict_updates(r);
    gap = sender_quiet ? 0 : pick_gap();
    if (gap != 0) begin
      frame.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every owed result has come, then lets
  // requests that yield nothing drain out of the block.
  task automatic wait_drained();
    frame.valid <= 1'b0;
    while (sb.due_updates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic drive_reg(input reg_index_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic apply_config(input logic [15:0] offset, input logic [15:0] period,
                              input logic [15:0] window, input logic [15:0] jitter);
    drive_reg(REG_TORQUE_TRIM, offset);
    drive_reg(REG_KEEPALIVE_PERIOD, period);
    drive_reg(REG_DROPOUT_WINDOW, window);
    drive_reg(REG_VOLTAGE_JITTER, jitter);
    cfg_we <= 1'b0;
  endtask

  // One phase of random requests, with a full drain halfway through.
  task automatic run_random(input int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      if (k % 60 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
      if (k == count / 2) wait_drained();
      push_request(random_request());
    end
  endtask

  // Result sink: checks each accepted result and stalls at random.
  initial begin
    int unsigned stall;
    int unsigned taken;
    result_t     got;
    stall      = 0;
    taken      = 0;
    sink_quiet = 1'b0;
    update.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && update.valid && update.ready) begin
        got.kind      = kind_t'(update.kind);
        got.last      = update.last;
        got.word_one  = update.word_one;
        got.word_two  = update.word_two;
        got.half_one  = update.half_one;
        got.half_two  = update.half_two;
        got.small_one = update.small_one;
        got.small_two = update.small_two;
        sb.check_update(got);
        taken++;
        if (taken % 150 == 0) sink_quiet = ($urandom_range(0, 2) == 0);
      end
      if (stall != 0) begin
        update.ready <= 1'b0;
        stall--;
      end else begin
        update.ready <= 1'b1;
        if (!sink_quiet) stall = pick_gap();
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    frame_req_t r;
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= REG_TORQUE_TRIM;
    cfg_data              <= '0;
    frame.valid           <= 1'b0;
    frame.cmd             <= 1'b0;
    frame.frame_ident     <= '0;
    frame.frame_length    <= '0;
    frame.payload         <= '0;
    frame.now_ms          <= '0;
    frame.requested_level <= '0;
    bus_ms       = '0;
    last_wheel   = '0;
    sender_quiet = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests under the reset configuration. Ticks before and
    // after the keepalive period runs out.
    push_request(tick_of(32'd50, LEVEL_3));
    push_request(tick_of(32'd101, LEVEL_WALK));
    // Pedal: first value, an exact repeat, a torque dropout, then full scale.
    push_request(frame_of(ID_PEDAL, 4'd8, {16'h0, 16'h0100, 8'h50, 24'h0}, 32'd120, LEVEL_1));
    push_request(frame_of(ID_PEDAL, 4'd8, {16'h0, 16'h0100, 8'h50, 24'h0}, 32'd125, LEVEL_1));
    push_request(frame_of(ID_PEDAL, 4'd8, {16'h0, 16'h0010, 8'h50, 24'h0}, 32'd130, LEVEL_1));
    push_request(frame_of(ID_PEDAL, 4'd8, {16'h0, 16'hFFFF, 8'hFF, 24'h0}, 32'd140, LEVEL_2));
    // Ride: temperatures that wrap below zero, then voltage at and past the jitter.
    push_request(frame_of(ID_RIDE, 4'd8, ride_bytes(16'hFFFF, 16'h0, 16'd1000, 8'h00, 8'hFF),
                          32'd150, LEVEL_2));
    push_request(frame_of(ID_RIDE, 4'd8, ride_bytes(16'hFFFF, 16'h0, 16'd1010, 8'h00, 8'hFF),
                          32'd160, LEVEL_2));
    push_request(frame_of(ID_RIDE, 4'd8, ride_bytes(16'hFFFF, 16'h0, 16'd1011, 8'h00, 8'hFF),
                          32'd170, LEVEL_2));
    // Wheel with the largest whole-inch size digits, together with a keepalive.
    push_request(frame_of(ID_WHEEL, 4'd6, {16'h0, 16'hFFFF, 8'hFF, 8'hF5, 16'h0000},
                          32'd205, 8'sd127));
    // Alive: hello, repeated hello, wrong length, goodbye, unknown byte.
    push_request(frame_of(ID_ALIVE, LEN_ALIVE, {56'h0, ALIVE_HELLO}, 32'd210, LEVEL_4));
    push_request(frame_of(ID_ALIVE, LEN_ALIVE, {56'h0, ALIVE_HELLO}, 32'd215, LEVEL_4));
    push_request(frame_of(ID_ALIVE, 4'd2, {56'h0, ALIVE_GOODBYE}, 32'd220, LEVEL_4));
    push_request(frame_of(ID_ALIVE, LEN_ALIVE, {56'h0, ALIVE_GOODBYE}, 32'd225, LEVEL_4));
    push_request(frame_of(ID_ALIVE, LEN_ALIVE, {56'h0, 8'h02}, 32'd230, LEVEL_4));
    // Assist: a level, the same level, an unknown code, walk.
    push_request(frame_of(ID_ASSIST, 4'd1, {56'h0, CODE_3}, 32'd240, LEVEL_5));
    push_request(frame_of(ID_ASSIST, 4'd1, {56'h0, CODE_3}, 32'd250, LEVEL_5));
    push_request(frame_of(ID_ASSIST, 4'd1, {56'h0, 8'h99}, 32'd260, LEVEL_5));
    push_request(frame_of(ID_ASSIST, 4'd1, {56'h0, CODE_WALK}, 32'd270, LEVEL_5));
    // Odometer with a full and a short frame.
    push_request(frame_of(ID_ODO, LEN_ODO, 64'hFFFF_FFFF_FFFF_FFFF, 32'd280, LEVEL_OFF));
    push_request(frame_of(ID_ODO, 4'd7, 64'h0123_4567_89AB_CDEF, 32'd290, LEVEL_OFF));
    // Unknown identifier, then time wrapping past the top of the counter.
    push_request(frame_of(29'h1FFF_FFFF, 4'd8, 64'hA5A5_5A5A_A5A5_5A5A, 32'd400, LEVEL_NONE));
    push_request(tick_of(32'hFFFF_FFF0, LEVEL_5));
    push_request(tick_of(32'h0000_0010, LEVEL_4));
    // A tick that carries a pedal identifier decodes nothing.
    r     = frame_of(ID_PEDAL, 4'd8, {16'h0, 16'h0300, 8'h10, 24'h0}, 32'h0000_0020, LEVEL_1);
    r.cmd = 1'b1;
    push_request(r);
    wait_drained();

    // Random phases, the extremes of every register but the smallest keepalive period among them.
    bus_ms = 32'h0000_0020;
    apply_config(16'h8000, 16'd1, 16'd0, 16'd0);
    run_random(ITEMS_PER_PHASE);
    wait_drained();
    apply_config(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(ITEMS_PER_PHASE);
    wait_drained();
    apply_config(16'hFED4, 16'd100, 16'd3000, 16'd10);
    run_random(ITEMS_PER_PHASE);
    wait_drained();
    apply_config(16'($urandom), 16'($urandom_range(1, 400)), 16'($urandom_range(0, 8000)),
                 16'($urandom_range(0, 40)));
    run_random(ITEMS_PER_PHASE);
    wait_drained();
    apply_config(16'd25, 16'd30, 16'd600, 16'd3);
    run_random(ITEMS_PER_PHASE);
    wait_drained();

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard limit on the run time.
  initial begin
    #(RUN_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[motor_can_frame_decoder.f]
design/mcfd_pkg.sv
design/mcfd_if.sv
design/mcfd_queue.sv
design/mcfd_front.sv
design/mcfd_back.sv
design/motor_can_frame_decoder.sv
design/mcfd_checker.sv
tb/sv/mcfd_sb_pkg.sv
tb/sv/tb_top.sv
